// ----- sv/ttrq_pkg.sv -----
// Shared constants, types and helpers of the timed task release queue.
`default_nettype none
package ttrq_pkg;

  // Store geometry and id width.
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NREL_W      = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 32;

  // Input kind codes.
  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  // Result status codes.
  localparam logic STATUS_RELEASED = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_INS,
    ST_INS_FIN,
    ST_TICK,
    ST_TICK_END
  } state_t;

  // One stored task.
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [TIME_W-1:0]  atime;
  } entry_t;

  // Circular index add; both operands are below QUEUE_DEPTH.
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/timed_task_release_queue_core.sv -----
// Top level of the timed task release queue: control, memory and output word.
//
// Timed task release queue. Input words carry tuser = kind (0 registers a task, 1 is a timer
// tick) and tdata = {arrival_time, task_id}. A registration whose time is already reached is
// answered with one released word; one into a full store is answered with a rejected word;
// otherwise the task is inserted in time order (ties keep arrival order) and no word comes out.
// A tick advances the time by one and releases every due task, oldest first, up to 16 per tick,
// tlast marking the final word. Tasks live in a circular single-write, registered-read memory.
// A registration answered at once or into an empty store is finished in ST_PROC; otherwise
// ST_INS moves each stored entry with a later time one place up, then the task is written.
// A tick on an empty store ends in ST_PROC; otherwise ST_TICK releases due tasks one by one,
// holding each back until the next is known, and ST_TICK_END sends the last. Output stalls
// lengthen both. Memory: one write, one registered read per cycle. No clearing pass is needed.
`default_nettype none
module timed_task_release_queue_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [7:0] task_id, [39:8] arrival_time
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] released_id, [39:8] event_time
  output logic             out_tuser,  // [0] status
  output logic             out_tlast
);
  import ttrq_pkg::*;

  // Control registers.
  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [NREL_W-1:0] nrel_r, nrel_nxt;
  logic              prev_v_r, prev_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic              kind_r, kind_nxt;
  entry_t            item_r, item_nxt;
  entry_t            prev_r, prev_nxt;
  logic [7:0]        out_id_r, out_id_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic              out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory port signals.
  entry_t            mem [QUEUE_DEPTH];
  entry_t            rd_data_r;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  entry_t            wr_data;

  logic out_free;
  logic due;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_time_r, out_id_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign due = (rd_data_r.atime <= now_r) && (nrel_r < NREL_W'(MAX_RESULTS));

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      head_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      nrel_r      <= '0;
      prev_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      nrel_r      <= nrel_nxt;
      prev_v_r    <= prev_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    item_r     <= item_nxt;
    prev_r     <= prev_nxt;
    out_id_r   <= out_id_nxt;
    out_time_r <= out_time_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  // Next state, memory accesses and output word.
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    nrel_nxt      = nrel_r;
    prev_v_nxt    = prev_v_r;
    out_valid_nxt = out_valid_r && !out_tready;
    kind_nxt      = kind_r;
    item_nxt      = item_r;
    prev_nxt      = prev_r;
    out_id_nxt    = out_id_r;
    out_time_nxt  = out_time_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt       = in_tuser;
          item_nxt.id    = in_tdata[ID_BITS-1:0];
          item_nxt.atime = in_tdata[39:8];
          if (in_tuser == KIND_TICK) begin
            now_nxt = now_r + 1'b1;
          end
          state_nxt = ST_PROC;
        end
      end

      ST_PROC: begin
        if (kind_r == KIND_TICK) begin
          // Start scanning the front of the store.
          nrel_nxt   = '0;
          prev_v_nxt = 1'b0;
          if (count_r != '0) begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            state_nxt = ST_TICK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if ((now_r >= item_r.atime) || (count_r == CNT_W'(QUEUE_DEPTH))) begin
          // Immediate release or rejection: one word.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = 8'(item_r.id);
            out_time_nxt  = now_r;
            out_stat_nxt  = (now_r >= item_r.atime) ? STATUS_RELEASED : STATUS_REJECTED;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (count_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = head_r;
          count_nxt = count_r + 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // Walk down from the tail to find the insertion place.
          pos_nxt   = IDX_W'(count_r - 1'b1);
          rd_en     = 1'b1;
          rd_addr   = idx_add(head_r, IDX_W'(count_r - 1'b1));
          state_nxt = ST_INS;
        end
      end

      ST_INS: begin
        wr_en = 1'b1;
        if (rd_data_r.atime > item_r.atime) begin
          // Later entry moves one place up.
          wr_addr = idx_add(head_r, pos_r + 1'b1);
          wr_data = rd_data_r;
          if (pos_r == '0) begin
            state_nxt = ST_INS_FIN;
          end else begin
            pos_nxt = pos_r - 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_add(head_r, pos_r - 1'b1);
          end
        end else begin
          wr_addr   = idx_add(head_r, pos_r + 1'b1);
          wr_data   = item_r;
          count_nxt = count_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_INS_FIN: begin
        // New task goes to the front.
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = item_r;
        count_nxt = count_r + 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_TICK: begin
        if (!due) begin
          state_nxt = ST_TICK_END;
        end else if (!prev_v_r || out_free) begin
          // Send the previous release, keep this one back until the next is known.
          if (prev_v_r) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = 8'(prev_r.id);
            out_time_nxt  = now_r;
            out_stat_nxt  = STATUS_RELEASED;
            out_last_nxt  = 1'b0;
          end
          prev_nxt   = rd_data_r;
          prev_v_nxt = 1'b1;
          head_nxt   = idx_add(head_r, IDX_W'(1));
          count_nxt  = count_r - 1'b1;
          nrel_nxt   = nrel_r + 1'b1;
          if (count_r > CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = idx_add(head_r, IDX_W'(1));
          end else begin
            state_nxt = ST_TICK_END;
          end
        end
      end

      ST_TICK_END: begin
        if (!prev_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = 8'(prev_r.id);
          out_time_nxt  = now_r;
          out_stat_nxt  = STATUS_RELEASED;
          out_last_nxt  = 1'b1;
          prev_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/ttrq_checker.sv -----
// Port-level checker for the timed task release queue, bound to the top level.
`default_nettype none
module ttrq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);
  import ttrq_pkg::*;

  // A pending output word is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // A rejection is always the only word of its item.
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_REJECTED) |-> out_tlast)
    else $error("rejected word without last");

  // An accepted word occupies the block for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind timed_task_release_queue_core ttrq_checker u_ttrq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
